// ===== rtl/asde_pkg.sv =====
// ----------------------------------------------------------------------------
// asde_pkg
// Shared widths, constants and the front-to-back item type of the airspeed
// sensor delay emulator.
// ----------------------------------------------------------------------------
package asde_pkg;

    // ring of timestamped samples
    localparam int RING_DEPTH = 64;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    // the write slot wraps at SLOT_SPAN, so at most 128 slots ever get used
    localparam int SLOT_SPAN  = (RING_DEPTH < 128) ? RING_DEPTH : 128;

    // field widths
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 20;
    localparam int DELAY_W = 16;
    localparam int OUT_W   = 16;
    localparam int RAW_W   = 26;
    localparam int ENTRY_W = TIME_W + RAW_W;

    // raw = floor(a^2 * 10000 / 5103616) + 2013*256; ratio reduced by 16
    localparam int SQ_W       = 2 * SPEED_W - 1;
    localparam int NUM_W      = 48;
    localparam int Q_W        = RAW_W;
    localparam int RATIO_MUL  = 625;
    localparam int RATIO_DIV  = 318976;
    localparam int RAW_OFFSET = 2013 * 256;
    localparam int RAW_LIMIT  = 262140 * 256;

    // saturated once the quotient reaches Q_SAT: compare the scaled square
    localparam int               Q_SAT   = RAW_LIMIT - RAW_OFFSET + 1;
    localparam logic [NUM_W-1:0] SAT_NUM = NUM_W'(Q_SAT) * NUM_W'(RATIO_DIV);

    // 318976 = 623 << 9; quotient by 623 from a reciprocal estimate
    localparam int RATIO_SH  = 9;
    localparam int RATIO_ODD = 623;
    localparam int N1_W      = NUM_W - RATIO_SH;
    localparam int EST_SH    = 10;
    localparam int RECIP_K   = 110304136;       // floor(2^36 / 623)
    localparam int RECIP_SH  = 26;
    localparam int PROD_W    = Q_W + 27;
    localparam int REM_W     = 12;

    // timing rules, milliseconds
    localparam int STORE_SPACING = 10;
    localparam int MATCH_WINDOW  = 200;
    localparam int DIST_W        = $clog2(MATCH_WINDOW + 1);

    localparam logic [OUT_W-1:0] SAT_VALUE = 16'hFFFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [RAW_W-1:0]  raw;
        logic              sat;
    } item_t;

endpackage

// ===== rtl/asde_ram.sv =====
// ----------------------------------------------------------------------------
// asde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/asde_front.sv =====
// ----------------------------------------------------------------------------
// asde_front
// Accepts an item, squares the speed and scales it by 10000/5103616 with a
// reciprocal estimate and a small remainder correction; flags saturation and
// hands the item to the queue.
// ----------------------------------------------------------------------------
module asde_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [asde_pkg::TIME_W-1:0]  s_now_ms,
    input  logic signed [asde_pkg::SPEED_W-1:0] s_airspeed,
    output asde_pkg::item_t                    q_item,
    output logic                               q_valid,
    input  logic                               q_ready
);
    import asde_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_MUL,
        ST_CHK,
        ST_REM,
        ST_FIX,
        ST_PUSH
    } state_t;

    state_t              state_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SPEED_W-1:0]  mag_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [Q_W-1:0]      est_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [Q_W-1:0]      q_reg;
    logic                presat_reg;

    logic [SPEED_W-1:0]   mag_in;
    logic [2*SPEED_W-1:0] sq_full;
    logic [NUM_W-1:0]     num;
    logic [N1_W-1:0]      num_hi;
    logic [PROD_W-1:0]    est_prod;
    logic [N1_W-1:0]      rem_full;
    logic [1:0]           fix;
    logic [RAW_W-1:0]     raw_sum;

    assign mag_in  = s_airspeed[SPEED_W-1] ? ($unsigned(~s_airspeed) + SPEED_W'(1))
                                           : $unsigned(s_airspeed);
    assign sq_full = mag_reg * mag_reg;
    assign num     = NUM_W'(sq_reg) * NUM_W'(RATIO_MUL);

    // estimate from the top bits is low by at most three
    assign num_hi   = num_reg[NUM_W-1:RATIO_SH];
    assign est_prod = PROD_W'(num_hi[EST_SH +: Q_W]) * PROD_W'(RECIP_K);
    assign rem_full = num_hi - N1_W'(est_reg) * N1_W'(RATIO_ODD);
    assign fix      = (rem_reg >= REM_W'(3 * RATIO_ODD)) ? 2'd3 :
                      (rem_reg >= REM_W'(2 * RATIO_ODD)) ? 2'd2 :
                      (rem_reg >= REM_W'(RATIO_ODD))     ? 2'd1 : 2'd0;
    assign raw_sum  = q_reg + RAW_W'(RAW_OFFSET);

    assign s_ready        = (state_reg == ST_IDLE);
    assign q_valid        = (state_reg == ST_PUSH);
    assign q_item.now_ms  = now_reg;
    assign q_item.raw     = raw_sum;
    assign q_item.sat     = presat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        now_reg   <= s_now_ms;
                        mag_reg   <= mag_in;
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    sq_reg    <= sq_full[SQ_W-1:0];
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    num_reg   <= num;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    // quotient at or past the limit: saturated, no quotient needed
                    presat_reg <= (num_reg >= SAT_NUM);
                    est_reg    <= est_prod[RECIP_SH +: Q_W];
                    state_reg  <= (num_reg >= SAT_NUM) ? ST_PUSH : ST_REM;
                end
                ST_REM: begin
                    rem_reg   <= rem_full[REM_W-1:0];
                    state_reg <= ST_FIX;
                end
                ST_FIX: begin
                    q_reg     <= est_reg + Q_W'(fix);
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (q_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_fix_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) |-> (rem_reg < REM_W'(4 * RATIO_ODD)))
        else $error("quotient estimate out of range");
`endif

endmodule

// ===== rtl/asde_queue.sv =====
// ----------------------------------------------------------------------------
// asde_queue
// Short register queue between front and back ends.
// ----------------------------------------------------------------------------
module asde_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  asde_pkg::item_t in_item,
    input  logic            in_valid,
    output logic            in_ready,
    output asde_pkg::item_t out_item,
    output logic            out_valid,
    input  logic            out_ready
);
    import asde_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic push;
    logic pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/asde_back.sv =====
// ----------------------------------------------------------------------------
// asde_back
// Stores spaced samples in the ring, scans it for the entry nearest the
// delayed time and drives the output register; saturated items skip both.
// ----------------------------------------------------------------------------
module asde_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asde_pkg::item_t               q_item,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [asde_pkg::DELAY_W-1:0]  delay_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [asde_pkg::OUT_W-1:0]    m_sensor_value
);
    import asde_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t            state_reg;
    item_t             item_reg;
    logic [TIME_W-1:0] last_store_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [RING_DEPTH-1:0] valid_reg;
    logic [TIME_W-1:0] target_reg;
    logic [ADDR_W-1:0] scan_addr_reg;
    logic              rd_pend_reg;
    logic              rd_ok_reg;
    logic              d_vld_reg;
    logic [TIME_W-1:0] d_reg;
    logic [RAW_W-1:0]  d_smp_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [RAW_W-1:0]  best_raw_reg;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_value_reg;

    logic              store_due;
    logic              ram_we;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [TIME_W-1:0] delay_ext;
    logic [TIME_W-1:0] target_next;
    logic [TIME_W-1:0] rd_time;
    logic [RAW_W-1:0]  rd_smp;
    logic [TIME_W-1:0] dist_now;
    logic              out_free;
    logic              match;
    logic [OUT_W-1:0]  result;

    assign store_due   = (item_reg.now_ms >= (last_store_reg + TIME_W'(STORE_SPACING)));
    assign ram_we      = (state_reg == ST_EVAL) && !item_reg.sat && store_due;
    assign ram_re      = (state_reg == ST_SCAN);
    assign delay_ext   = TIME_W'(delay_ms);
    assign target_next = (item_reg.now_ms > delay_ext) ? (item_reg.now_ms - delay_ext)
                                                       : item_reg.now_ms;

    // entries never written read as time 0, sample 0
    assign rd_time  = rd_ok_reg ? ram_rdata[RAW_W +: TIME_W] : '0;
    assign rd_smp   = rd_ok_reg ? ram_rdata[RAW_W-1:0] : '0;
    assign dist_now = (target_reg > rd_time) ? (target_reg - rd_time)
                                             : (rd_time - target_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign match    = (best_dist_reg < DIST_W'(MATCH_WINDOW));
    assign result   = item_reg.sat ? SAT_VALUE :
                      match        ? best_raw_reg[RAW_W-1 -: OUT_W]
                                   : item_reg.raw[RAW_W-1 -: OUT_W];

    assign q_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sensor_value = m_value_reg;

    asde_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({item_reg.now_ms, item_reg.raw}),
        .re    (ram_re),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // scan pipeline: read, distance, compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            d_vld_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= ram_re;
            d_vld_reg   <= rd_pend_reg;
        end
        rd_ok_reg <= valid_reg[scan_addr_reg];
        d_reg     <= dist_now;
        d_smp_reg <= rd_smp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_store_reg <= '0;
            slot_reg       <= '0;
            valid_reg      <= '0;
            scan_addr_reg  <= '0;
            best_dist_reg  <= DIST_W'(MATCH_WINDOW);
            m_valid_reg    <= 1'b0;
        end else begin
            if (d_vld_reg && (d_reg < TIME_W'(best_dist_reg))) begin
                best_dist_reg <= DIST_W'(d_reg);
                best_raw_reg  <= d_smp_reg;
            end

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                m_value_reg <= result;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    best_dist_reg <= DIST_W'(MATCH_WINDOW);
                    target_reg    <= target_next;
                    scan_addr_reg <= '0;
                    if (item_reg.sat) begin
                        state_reg <= ST_OUT;
                    end else begin
                        if (store_due) begin
                            last_store_reg      <= item_reg.now_ms;
                            valid_reg[slot_reg] <= 1'b1;
                            slot_reg <= (slot_reg == ADDR_W'(SLOT_SPAN - 1)) ? '0
                                                                            : slot_reg + 1'b1;
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (scan_addr_reg == ADDR_W'(RING_DEPTH - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_pend_reg && !d_vld_reg) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_best_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        best_dist_reg <= DIST_W'(MATCH_WINDOW))
        else $error("best distance above match window");

    a_drained_at_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (!rd_pend_reg && !d_vld_reg))
        else $error("result taken before scan pipeline drained");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, slot_reg} < (ADDR_W+1)'(SLOT_SPAN))
        else $error("write slot out of range");
`endif

endmodule

// ===== rtl/airspeed_sensor_delay_emulator.sv =====
// ----------------------------------------------------------------------------
// airspeed_sensor_delay_emulator
// Turns airspeed into a raw pressure reading and answers with the ring sample
// nearest to (now - delay), emulating a delayed airspeed sensor.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+-----------------------
//  s_       | s_valid s_ready s_now_ms s_airspeed     | input transfer
//  m_       | m_valid m_ready m_sensor_value          | result transfer
//  cfg_     | cfg_valid cfg_ready cfg_delay_ms        | delay register write
//
//  Throughput: set by the back-end ring scan at one RAM read per cycle; the
//  back end takes a new item only once the last one has left. The front end
//  (square, scale, reciprocal estimate, remainder, correction, hand-off)
//  overlaps it through a two-entry queue. Saturated items skip the scan and,
//  in front, the remainder and correction steps.
//  Reset: synchronous, active low; ring valid bits clear at once, no sweep.
//  Stalls: a result waits in the output register while the front keeps taking
//  items until the queue fills.
// ----------------------------------------------------------------------------
module airspeed_sensor_delay_emulator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [asde_pkg::TIME_W-1:0]  s_now_ms,
    input  logic signed [asde_pkg::SPEED_W-1:0] s_airspeed,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [asde_pkg::OUT_W-1:0]   m_sensor_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [asde_pkg::DELAY_W-1:0] cfg_delay_ms
);
    import asde_pkg::*;

    logic [DELAY_W-1:0] delay_ms_reg;

    item_t fq_item;
    logic  fq_valid;
    logic  fq_ready;
    item_t qb_item;
    logic  qb_valid;
    logic  qb_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ms_reg <= '0;
        end else if (cfg_valid) begin
            delay_ms_reg <= cfg_delay_ms;
        end
    end

    asde_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_now_ms   (s_now_ms),
        .s_airspeed (s_airspeed),
        .q_item     (fq_item),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready)
    );

    asde_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (fq_item),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .out_item  (qb_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready)
    );

    asde_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_item         (qb_item),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .delay_ms       (delay_ms_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sensor_value (m_sensor_value)
    );

endmodule

// ===== dv/airspeed_sensor_delay_emulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airspeed_sensor_delay_emulator_tb
// Self-checking bench for the delayed airspeed sensor. A clocked driver feeds
// timestamped airspeed transfers from a queue. A monitor keeps its own copy of
// the sample ring and works out the delayed reading for every accepted
// transfer. Each returned reading is checked against the oldest expected one.
// The delay register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module airspeed_sensor_delay_emulator_tb;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1_500_000;
    localparam int          TAIL_CYCLES  = 200;
    localparam int          TRACK_LEN    = 150;

    // raw reading = a^2 * 10000 / 5103616 + 2013*256, Q18.8
    localparam longint unsigned PA_NUM   = 64'd10000;
    localparam longint unsigned PA_DEN   = 64'd5103616;
    localparam longint unsigned RAW_BIAS = 64'd515328;
    localparam longint unsigned RAW_CEIL = 64'd67107840;
    localparam logic [31:0]     SPACING_MS  = 32'd10;
    localparam logic [31:0]     WINDOW_MS   = 32'd200;
    localparam logic [15:0]     SAT_READING = 16'hFFFF;
    localparam int              RING_N      = asde_pkg::RING_DEPTH;

    typedef struct {
        logic [asde_pkg::TIME_W-1:0]  now_ms;
        logic [asde_pkg::SPEED_W-1:0] airspeed;
    } speed_sample_t;

    logic                                aclk;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic        [asde_pkg::TIME_W-1:0]  s_now_ms       = '0;
    logic signed [asde_pkg::SPEED_W-1:0] s_airspeed     = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic        [asde_pkg::OUT_W-1:0]   m_sensor_value;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic        [asde_pkg::DELAY_W-1:0] cfg_delay_ms   = '0;

    speed_sample_t               pending_samples[$];
    logic [asde_pkg::OUT_W-1:0]  expected_readings[$];

    // mirror of the block's ring and register
    logic [asde_pkg::RAW_W-1:0]   ring_raw   [RING_N] = '{default: '0};
    logic [asde_pkg::TIME_W-1:0]  ring_stamp [RING_N] = '{default: '0};
    logic [6:0]                   next_slot       = '0;
    logic [31:0]                  last_stored_at  = '0;
    logic [asde_pkg::DELAY_W-1:0] delay_setting   = '0;

    logic [31:0] track_ms    = '0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_gap    = 0;
    bit          send_calm   = 1'b0;
    bit          in_taken    = 1'b0;
    int          sink_stall  = 0;
    bit          sink_calm   = 1'b0;

    airspeed_sensor_delay_emulator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_now_ms       (s_now_ms),
        .s_airspeed     (s_airspeed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sensor_value (m_sensor_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_delay_ms   (cfg_delay_ms)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // converts; unless saturated, stores if due, then looks up the ring entry nearest to now - delay
    function automatic logic [15:0] delayed_reading(input logic [31:0] now,
                                                    input logic [19:0] spd);
        longint unsigned mag;
        longint unsigned raw;
        logic [31:0]     target;
        logic [31:0]     gap_ms;
        logic [31:0]     best_dist;
        int              best_idx;
        mag = spd[19] ? (64'h10_0000 - {44'd0, spd}) : {44'd0, spd};
        raw = (mag * mag * PA_NUM) / PA_DEN + RAW_BIAS;
        if (raw > RAW_CEIL)
            return SAT_READING;
        if (now >= 32'(last_stored_at + SPACING_MS)) begin
            last_stored_at = now;
            if (next_slot >= RING_N)
                next_slot = '0;
            ring_raw[next_slot]   = raw[25:0];
            ring_stamp[next_slot] = now;
            next_slot             = next_slot + 7'd1;
        end
        target    = (now > {16'd0, delay_setting}) ? now - {16'd0, delay_setting} : now;
        best_dist = WINDOW_MS;
        best_idx  = 0;
        for (int i = 0; i < RING_N; i++) begin
            gap_ms = (target > ring_stamp[i]) ? target - ring_stamp[i]
                                              : ring_stamp[i] - target;
            if (gap_ms < best_dist) begin
                best_dist = gap_ms;
                best_idx  = i;
            end
        end
        if (best_dist < WINDOW_MS)
            raw = {38'd0, ring_raw[best_idx]};
        return raw[25:10];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [19:0] pick_speed();
        int          r;
        int unsigned mag;
        logic [19:0] bits;
        r = $urandom_range(0, 99);
        if (r < 45)
            mag = $urandom_range(0, 20000);
        else if (r < 75)
            mag = $urandom_range(0, 184353);
        else if (r < 85)
            mag = $urandom_range(184350, 184357);   // around the saturation edge
        else if (r < 95)
            return 20'($urandom);
        else begin
            case ($urandom_range(0, 3))
                0:       return 20'h7FFFF;
                1:       return 20'h80000;
                2:       return 20'h00001;
                default: return 20'hFFFFF;
            endcase
        end
        bits = 20'(mag);
        return $urandom_range(0, 1) ? -bits : bits;
    endfunction

    task automatic queue_sample(input logic [31:0] now, input logic [19:0] spd);
        speed_sample_t smp;
        smp.now_ms   = now;
        smp.airspeed = spd;
        pending_samples.push_back(smp);
    endtask

    // mostly steady time steps, with holds, jumps and the odd wild one
    task automatic queue_track(input int count);
        int          pick;
        logic [31:0] step;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                step = $urandom_range(1, 25);
            else if (pick < 88)
                step = '0;
            else if (pick < 94)
                step = $urandom_range(26, 400);
            else if (pick < 99)
                step = $urandom_range(401, 70000);
            else
                step = $urandom;
            track_ms = track_ms + step;
            queue_sample(track_ms, pick_speed());
        end
    endtask

    task automatic drain_all();
        while (pending_samples.size() != 0 || s_valid || expected_readings.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_delay(input logic [15:0] value);
        @(negedge aclk);
        cfg_delay_ms <= value;
        cfg_valid    <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_track(input logic [15:0] delay);
        write_delay(delay);
        queue_track(TRACK_LEN);
        drain_all();
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn || (s_valid && !in_taken)) begin
            // hold the current transfer
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
            s_now_ms   <= pending_samples[0].now_ms;
            s_airspeed <= pending_samples[0].airspeed;
            s_valid    <= 1'b1;
            void'(pending_samples.pop_front());
            if ($urandom_range(0, 59) == 0)
                send_calm = !send_calm;
            send_gap = send_calm ? 0 : pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
            if ($urandom_range(0, 199) == 0)
                sink_calm = !sink_calm;
            if (!sink_calm && $urandom_range(0, 2) == 0)
                sink_stall = pick_gap();
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        in_taken = s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                delay_setting = cfg_delay_ms;
            if (in_taken)
                expected_readings.push_back(delayed_reading(s_now_ms, s_airspeed));
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0)
                    report_mismatch($sformatf("unexpected reading %0d", m_sensor_value));
                else if (m_sensor_value !== expected_readings[0])
                    report_mismatch($sformatf("sensor_value got %0d want %0d",
                                              m_sensor_value, expected_readings[0]));
                if (expected_readings.size() != 0)
                    void'(expected_readings.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, delay at its reset value of zero; first item is too early to store
        queue_sample(32'd0,  20'd0);
        queue_sample(32'd5,  20'd1);
        queue_sample(32'd10, -20'sd1);
        queue_sample(32'd10, 20'h7FFFF);
        queue_sample(32'd11, 20'h80000);
        queue_sample(32'd20, 20'sd184353);
        queue_sample(32'd30, -20'sd184353);
        queue_sample(32'd31, 20'sd184354);
        queue_sample(32'd45, -20'sd184354);
        queue_sample(32'd60, 20'd7680);
        queue_sample(32'd2000, 20'd12800);
        queue_sample(32'd2005, 20'd256);
        drain_all();

        // long delay: small now, spacing across the counter wrap
        write_delay(16'd1000);
        queue_sample(32'd2500, 20'd10240);
        queue_sample(32'd500,  20'd2560);
        queue_sample(32'd150,  -20'sd2560);
        queue_sample(32'hFFFF_FFF0, 20'd5000);
        queue_sample(32'hFFFF_FFF8, 20'd6000);
        queue_sample(32'hFFFF_FFFC, 20'd7000);
        queue_sample(32'd2, 20'd8000);          // lands on never-written entries
        queue_sample(32'd7, 20'd9000);
        drain_all();

        track_ms = 32'd7;
        run_track(16'hFFFF);
        run_track(16'd0);
        run_track(16'd450);
        run_track(16'd1);
        track_ms = 32'hFFFF_F000;               // run straight through the wrap
        run_track(16'd199);
        run_track(16'd200);
        run_track(16'($urandom_range(0, 65535)));
        run_track(16'($urandom_range(0, 900)));

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d readings never returned", expected_readings.size()));
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
